[sv/sdsrr_pkg.sv]
// Package: shared constants, register map and sequencer states of the replacement engine.
package sdsrr_pkg;

  localparam int unsigned NUM_SETS_DEF    = 2048;
  localparam int unsigned NUM_WAYS_DEF    = 16;
  localparam int unsigned LEADER_SETS_DEF = 32;
  localparam int unsigned SIG_BITS_DEF    = 6;

  localparam logic [1:0]  RRPV_MAX    = 2'd3;
  localparam logic [1:0]  RRPV_BIP    = 2'd2;
  localparam logic [9:0]  PSEL_MID    = 10'd512;
  localparam logic [9:0]  PSEL_MAX    = 10'd1023;
  localparam logic [15:0] LFSR_TAPS   = 16'hB400;
  localparam int unsigned BIP_BITS    = 5;
  localparam int unsigned SIG_SHIFT   = 6;

  localparam logic [1:0]  THR_RST     = 2'd3;
  localparam logic [15:0] DECAY_RST   = 16'd4096;
  localparam logic [15:0] SEED_RST    = 16'd44257;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_DECAY     = 2'd1;
  localparam logic [1:0] REG_SEED      = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPD,
    ST_AGE,
    ST_VREAD,
    ST_FILL,
    ST_OUT,
    ST_DEC_RD,
    ST_DEC_WR
  } state_e;

endpackage

[sv/sdsrr_ram.sv]
// Generic simple dual-port RAM with registered read.
module sdsrr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/ship_dip_streaming_rrip_replacement.sv]
// Top level: SRRIP victim selection with SHiP prediction, DIP dueling and stream detection.
//
// One access word in gives one result word out. After reset the engine clears all
// of its tables before it takes the first word. A hit passes through the read, update
// and output states; a miss also passes through aging, victim read and fill, the
// aging loop repeating until some way reaches RRPV 3. Every decay_interval fills the
// stream counters are lowered by a sweep through the stream counter RAM, a read and
// a write state per set, during which no word is taken. All per-set and per-block
// state lives in single-port-read RAMs read once per step of the sequencer. NUM_SETS
// and NUM_WAYS must be powers of two.
module ship_dip_streaming_rrip_replacement
  import sdsrr_pkg::*;
#(
  parameter int unsigned NUM_SETS    = NUM_SETS_DEF,
  parameter int unsigned NUM_WAYS    = NUM_WAYS_DEF,
  parameter int unsigned LEADER_SETS = LEADER_SETS_DEF,
  parameter int unsigned SIG_BITS    = SIG_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [10:0] set_index, [14:11] hit_way, [78:15] pc, [142:79] phys_addr, [143] zero
  input  logic [143:0] s_axis_tdata_i,
  // [0] hit
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [3:0] way, [5:4] new_rrpv, [6] streaming, [7] lip_chosen
  output logic [7:0]   m_axis_tdata_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned SET_W   = $clog2(NUM_SETS);
  localparam int unsigned SX_W    = (SET_W > 11) ? SET_W : 11;
  localparam int unsigned WAY_W   = $clog2(NUM_WAYS);
  localparam int unsigned WX_W    = (WAY_W > 4) ? WAY_W : 4;
  localparam int unsigned SIG_N   = 1 << SIG_BITS;
  localparam int unsigned ENT_W   = SIG_BITS + 2;
  localparam int unsigned ROW_W   = NUM_WAYS * ENT_W;
  localparam int unsigned CLR_N   = (NUM_SETS > SIG_N) ? NUM_SETS : SIG_N;
  localparam int unsigned CLR_W   = $clog2(CLR_N);

  state_e state_q, state_d;

  // configuration
  logic [1:0]  thr_q;
  logic [15:0] decay_q;
  logic [15:0] seed_q;
  logic [15:0] rs_q;
  logic        cfg_we;

  // latched access
  logic [SET_W-1:0]    set_q;
  logic                hit_q;
  logic [WAY_W-1:0]    hway_q;
  logic [63:0]         addr_q;
  logic [SIG_BITS-1:0] sig_q;
  logic [SX_W-1:0]     set_ext;
  logic [WX_W-1:0]     way_ext;

  // working state
  logic [ROW_W-1:0]    row_q;
  logic [1:0]          sigc_q;
  logic [WAY_W-1:0]    vway_q;
  logic [SIG_BITS-1:0] vsig_q;
  logic                strm_q;
  logic [9:0]          psel_q;
  logic [15:0]         fill_q;
  logic                decay_pend_q;
  logic [CLR_W-1:0]    clr_q;
  logic [SET_W-1:0]    dcnt_q;

  // result staging and output register
  logic [WAY_W-1:0] res_way_q;
  logic [1:0]       res_rrpv_q;
  logic             res_lip_q;
  logic             ovalid_q;
  logic [7:0]       odata_q;

  // RAM ports
  logic                blk_we, hist_we, strm_we, outc_we;
  logic [SET_W-1:0]    blk_wa, hist_wa, strm_wa, set_ra, strm_ra;
  logic [ROW_W-1:0]    blk_wd, blk_rd;
  logic [127:0]        hist_wd, hist_rd;
  logic [1:0]          strm_wd, strm_rd, outc_wd, outc_rd;
  logic [SIG_BITS-1:0] outc_wa, outc_ra;

  // combinational helpers
  logic             lip_leader, bip_leader, use_lip;
  logic [63:0]      delta;
  logic             stride_up;
  logic [1:0]       cnt_new;
  logic             clr_set, clr_sig;
  logic             found;
  logic [WAY_W-1:0] first3;
  logic [ROW_W-1:0] aged_row, hit_row, fill_row;
  logic [15:0]      rs_step;
  logic [1:0]       ins;
  logic [15:0]      fill_inc;
  logic             out_free;

  assign set_ext = SX_W'(s_axis_tdata_i[10:0]);
  assign way_ext = WX_W'(s_axis_tdata_i[14:11]);

  assign lip_leader = ({1'b0, set_q} < (SET_W+1)'(LEADER_SETS));
  assign bip_leader = !lip_leader &&
                      ((SET_W+1)'(set_q) + (SET_W+1)'(LEADER_SETS) >= (SET_W+1)'(NUM_SETS));
  assign use_lip    = lip_leader || (!bip_leader && psel_q >= PSEL_MID);

  assign delta     = addr_q - hist_rd[63:0];
  assign stride_up = (hist_rd[63:0] != 64'd0) && (delta != 64'd0) && (delta == hist_rd[127:64]);
  always_comb begin
    cnt_new = strm_rd;
    if (stride_up) begin
      if (strm_rd != 2'd3) cnt_new = strm_rd + 2'd1;
    end else if (strm_rd != 2'd0) begin
      cnt_new = strm_rd - 2'd1;
    end
  end

  assign clr_set = ({1'b0, clr_q} < (CLR_W+1)'(NUM_SETS));
  assign clr_sig = ({1'b0, clr_q} < (CLR_W+1)'(SIG_N));

  // victim search and aging over the buffered row
  always_comb begin
    found    = 1'b0;
    first3   = '0;
    aged_row = row_q;
    for (int w = NUM_WAYS-1; w >= 0; w--) begin
      if (row_q[w*ENT_W +: 2] == RRPV_MAX) begin
        found  = 1'b1;
        first3 = WAY_W'(w);
      end
      aged_row[w*ENT_W +: 2] = row_q[w*ENT_W +: 2] + 2'd1;
    end
  end

  always_comb begin
    hit_row = blk_rd;
    hit_row[hway_q*ENT_W +: ENT_W] = {sig_q, 2'b00};
  end

  assign rs_step = {1'b0, rs_q[15:1]} ^ (rs_q[0] ? LFSR_TAPS : 16'd0);

  always_comb begin
    if (use_lip) begin
      ins = RRPV_MAX;
    end else begin
      ins = (rs_step[BIP_BITS-1:0] == '0) ? RRPV_BIP : RRPV_MAX;
    end
    if (sigc_q >= 2'd2) begin
      ins = 2'd0;
    end else if (sigc_q == 2'd0) begin
      ins = RRPV_MAX;
    end
    if (strm_q) ins = RRPV_MAX;
  end

  always_comb begin
    fill_row = row_q;
    fill_row[vway_q*ENT_W +: ENT_W] = {sig_q, ins};
  end

  assign fill_inc = fill_q + 16'd1;
  assign out_free = !ovalid_q || m_axis_tready_i;

  // sequencer and RAM control
  always_comb begin
    state_d = state_q;
    blk_we  = 1'b0;
    hist_we = 1'b0;
    strm_we = 1'b0;
    outc_we = 1'b0;
    blk_wa  = set_q;
    hist_wa = set_q;
    strm_wa = set_q;
    outc_wa = sig_q;
    blk_wd  = hit_row;
    hist_wd = {delta, addr_q};
    strm_wd = cnt_new;
    outc_wd = (outc_rd != 2'd3) ? outc_rd + 2'd1 : outc_rd;
    set_ra  = set_q;
    strm_ra = set_q;
    outc_ra = sig_q;
    case (state_q)
      ST_CLEAR: begin
        blk_we  = clr_set;
        hist_we = clr_set;
        strm_we = clr_set;
        outc_we = clr_sig;
        blk_wa  = clr_q[SET_W-1:0];
        hist_wa = clr_q[SET_W-1:0];
        strm_wa = clr_q[SET_W-1:0];
        outc_wa = clr_q[SIG_BITS-1:0];
        blk_wd  = {NUM_WAYS{{SIG_BITS{1'b0}}, RRPV_MAX}};
        hist_wd = '0;
        strm_wd = '0;
        outc_wd = '0;
        if (clr_q == CLR_W'(CLR_N-1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = ST_READ;
      end
      ST_READ: state_d = ST_UPD;
      ST_UPD: begin
        hist_we = 1'b1;
        strm_we = 1'b1;
        blk_we  = hit_q;
        outc_we = hit_q;
        state_d = hit_q ? ST_OUT : ST_AGE;
      end
      ST_AGE: begin
        if (found) state_d = ST_VREAD;
      end
      ST_VREAD: begin
        outc_ra = vsig_q;
        state_d = ST_FILL;
      end
      ST_FILL: begin
        blk_we  = 1'b1;
        blk_wd  = fill_row;
        outc_we = 1'b1;
        outc_wa = vsig_q;
        outc_wd = (outc_rd != 2'd0) ? outc_rd - 2'd1 : outc_rd;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = decay_pend_q ? ST_DEC_RD : ST_IDLE;
      end
      ST_DEC_RD: begin
        strm_ra = dcnt_q;
        state_d = ST_DEC_WR;
      end
      ST_DEC_WR: begin
        strm_we = 1'b1;
        strm_wa = dcnt_q;
        strm_wd = (strm_rd != 2'd0) ? strm_rd - 2'd1 : strm_rd;
        state_d = (dcnt_q == SET_W'(NUM_SETS-1)) ? ST_IDLE : ST_DEC_RD;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= THR_RST;
      decay_q      <= DECAY_RST;
      seed_q       <= SEED_RST;
      rs_q         <= SEED_RST;
      psel_q       <= PSEL_MID;
      fill_q       <= '0;
      decay_pend_q <= 1'b0;
      clr_q        <= '0;
      dcnt_q       <= '0;
      ovalid_q     <= 1'b0;
    end else begin
      if (state_q == ST_CLEAR) clr_q <= clr_q + CLR_W'(1);
      if (cfg_we) begin
        case (paddr[3:2])
          REG_THRESHOLD: thr_q <= pwdata[1:0];
          REG_DECAY:     decay_q <= pwdata[15:0];
          REG_SEED: begin
            seed_q <= pwdata[15:0];
            rs_q   <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
          end
          default: ;
        endcase
      end
      if (state_q == ST_UPD && hit_q) begin
        if (lip_leader) begin
          if (psel_q != PSEL_MAX) psel_q <= psel_q + 10'd1;
        end else if (bip_leader) begin
          if (psel_q != 10'd0) psel_q <= psel_q - 10'd1;
        end
      end
      if (state_q == ST_FILL) begin
        if (!use_lip) rs_q <= rs_step;
        // count the fill and arm the decay sweep
        if (fill_inc >= decay_q) begin
          fill_q       <= '0;
          decay_pend_q <= 1'b1;
        end else begin
          fill_q <= fill_inc;
        end
      end
      if (state_q == ST_OUT && out_free) begin
        ovalid_q     <= 1'b1;
        decay_pend_q <= 1'b0;
        dcnt_q       <= '0;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
      if (state_q == ST_DEC_WR) dcnt_q <= dcnt_q + SET_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid_i) begin
      set_q  <= set_ext[SET_W-1:0];
      hit_q  <= s_axis_tuser_i;
      hway_q <= way_ext[WAY_W-1:0];
      addr_q <= s_axis_tdata_i[142:79];
      sig_q  <= s_axis_tdata_i[15 +: SIG_BITS] ^ s_axis_tdata_i[79+SIG_SHIFT +: SIG_BITS];
    end
    if (state_q == ST_UPD) begin
      row_q      <= blk_rd;
      sigc_q     <= outc_rd;
      strm_q     <= (cnt_new >= thr_q);
      res_way_q  <= hway_q;
      res_rrpv_q <= 2'd0;
      res_lip_q  <= 1'b0;
    end
    if (state_q == ST_AGE) begin
      if (found) begin
        vway_q <= first3;
        vsig_q <= row_q[first3*ENT_W+2 +: SIG_BITS];
      end else begin
        row_q <= aged_row;
      end
    end
    if (state_q == ST_FILL) begin
      res_way_q  <= vway_q;
      res_rrpv_q <= ins;
      res_lip_q  <= use_lip;
    end
    if (state_q == ST_OUT && out_free) begin
      odata_q <= {res_lip_q, strm_q, res_rrpv_q, 4'(res_way_q)};
    end
  end

  sdsrr_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_blk_ram (
    .clk_i(clk_i), .we_i(blk_we), .waddr_i(blk_wa), .wdata_i(blk_wd),
    .raddr_i(set_ra), .rdata_o(blk_rd)
  );

  sdsrr_ram #(.WIDTH(128), .DEPTH(NUM_SETS)) u_hist_ram (
    .clk_i(clk_i), .we_i(hist_we), .waddr_i(hist_wa), .wdata_i(hist_wd),
    .raddr_i(set_ra), .rdata_o(hist_rd)
  );

  sdsrr_ram #(.WIDTH(2), .DEPTH(NUM_SETS)) u_strm_ram (
    .clk_i(clk_i), .we_i(strm_we), .waddr_i(strm_wa), .wdata_i(strm_wd),
    .raddr_i(strm_ra), .rdata_o(strm_rd)
  );

  sdsrr_ram #(.WIDTH(2), .DEPTH(SIG_N)) u_outc_ram (
    .clk_i(clk_i), .we_i(outc_we), .waddr_i(outc_wa), .wdata_i(outc_wd),
    .raddr_i(outc_ra), .rdata_o(outc_rd)
  );

  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD: prdata = {30'd0, thr_q};
      REG_DECAY:     prdata = {16'd0, decay_q};
      REG_SEED:      prdata = {16'd0, seed_q};
      default:       prdata = 32'd0;
    endcase
  end

  assign pready          = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

endmodule

[tb/tb_ship_dip_streaming_rrip_replacement.sv]
// Testbench: random and directed cache accesses checked against a behavioral replacement model.
`timescale 1ns / 100ps

module tb_ship_dip_streaming_rrip_replacement;
  import sdsrr_pkg::*;

  localparam int unsigned SETS  = NUM_SETS_DEF;
  localparam int unsigned WAYS  = NUM_WAYS_DEF;
  localparam int unsigned LEAD  = LEADER_SETS_DEF;
  localparam int unsigned SIGN  = 1 << SIG_BITS_DEF;
  localparam int unsigned DRAIN = 4400;

  typedef struct packed {
    logic [10:0] set_index;
    logic        hit;
    logic [3:0]  hit_way;
    logic [63:0] pc;
    logic [63:0] phys_addr;
  } access_t;

  typedef struct packed {
    logic [3:0] way;
    logic [1:0] new_rrpv;
    logic       streaming;
    logic       lip_chosen;
  } outcome_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [143:0] s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [7:0]   m_axis_tdata_o;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  ship_dip_streaming_rrip_replacement i_dut (.*);

  always #5 clk_i = ~clk_i;

  // replacement state mirror
  logic [1:0]  blk_rrpv [0:SETS*WAYS-1];
  logic [5:0]  blk_sig  [0:SETS*WAYS-1];
  logic [1:0]  sig_ctr  [0:SIGN-1];
  logic [63:0] prev_addr   [0:SETS-1];
  logic [63:0] prev_stride [0:SETS-1];
  logic [1:0]  strm_ctr   [0:SETS-1];
  logic [9:0]  psel_ctr;
  logic [15:0] fills;
  logic [15:0] lfsr;
  logic [1:0]  thr_cfg;
  logic [15:0] decay_cfg;

  access_t  pending_accesses [$];
  outcome_t expected_results [$];
  int errors = 0, n_sent = 0, n_hits = 0, n_strm = 0, n_lip = 0, n_got = 0;
  bit no_idle = 0, sink_hold = 0;

  logic [63:0] gen_addr [0:SETS-1];
  logic [63:0] gen_stride [0:SETS-1];
  logic [63:0] pc_pool [0:7];
  int unsigned set_pool [0:7] = '{0, 5, 31, 100, 777, 2016, 2047, 1024};

  function automatic outcome_t compute_replacement(access_t a);
    outcome_t    r;
    int unsigned s, base, v, ins;
    logic [5:0]  sg, vs;
    logic [63:0] d;
    logic [1:0]  mx;
    bit          lip_l, bip_l, use_lip;
    s = a.set_index;
    base = s * WAYS;
    sg = a.pc[5:0] ^ a.phys_addr[11:6];
    d = a.phys_addr - prev_addr[s];
    lip_l = s < LEAD;
    bip_l = !lip_l && s >= SETS - LEAD;
    if (prev_addr[s] != 0 && d != 0 && d == prev_stride[s]) begin
      if (strm_ctr[s] != 2'd3) strm_ctr[s]++;
    end else if (strm_ctr[s] != 0) begin
      strm_ctr[s]--;
    end
    prev_stride[s] = d;
    prev_addr[s] = a.phys_addr;
    r.streaming = strm_ctr[s] >= thr_cfg;
    if (a.hit) begin
      blk_rrpv[base + a.hit_way] = 2'd0;
      blk_sig[base + a.hit_way] = sg;
      if (sig_ctr[sg] != 2'd3) sig_ctr[sg]++;
      if (lip_l && psel_ctr != PSEL_MAX) psel_ctr++;
      else if (bip_l && psel_ctr != 0) psel_ctr--;
      r.way = a.hit_way;
      r.new_rrpv = 2'd0;
      r.lip_chosen = 1'b0;
      return r;
    end
    mx = 0;
    for (int w = 0; w < WAYS; w++) if (blk_rrpv[base + w] > mx) mx = blk_rrpv[base + w];
    for (int w = 0; w < WAYS; w++) blk_rrpv[base + w] += RRPV_MAX - mx;
    v = 0;
    for (int w = WAYS - 1; w >= 0; w--) if (blk_rrpv[base + w] == RRPV_MAX) v = w;
    use_lip = lip_l ? 1'b1 : bip_l ? 1'b0 : psel_ctr >= PSEL_MID;
    if (use_lip) begin
      ins = RRPV_MAX;
    end else begin
      lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
      ins = (lfsr[BIP_BITS-1:0] == 0) ? RRPV_BIP : RRPV_MAX;
    end
    if (sig_ctr[sg] >= 2) ins = 0;
    else if (sig_ctr[sg] == 0) ins = RRPV_MAX;
    if (r.streaming) ins = RRPV_MAX;
    vs = blk_sig[base + v];
    if (sig_ctr[vs] != 0) sig_ctr[vs]--;
    blk_rrpv[base + v] = ins[1:0];
    blk_sig[base + v] = sg;
    fills++;
    if (fills >= decay_cfg) begin
      fills = 0;
      for (int k = 0; k < SETS; k++) if (strm_ctr[k] != 0) strm_ctr[k]--;
    end
    r.way = v[3:0];
    r.new_rrpv = ins[1:0];
    r.lip_chosen = use_lip;
    return r;
  endfunction

  function automatic int gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // driver
  int src_gap = 0;
  always @(posedge clk_i) begin
    logic    nv;
    access_t a;
    nv = s_axis_tvalid_i;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      a = {s_axis_tdata_i[10:0], s_axis_tuser_i, s_axis_tdata_i[14:11],
           s_axis_tdata_i[78:15], s_axis_tdata_i[142:79]};
      expected_results.push_back(compute_replacement(a));
      n_sent++;
      nv = 1'b0;
    end
    if (!nv) begin
      if (src_gap > 0) begin
        src_gap--;
      end else if (pending_accesses.size() > 0) begin
        a = pending_accesses.pop_front();
        s_axis_tdata_i <= {1'b0, a.phys_addr, a.pc, a.hit_way, a.set_index};
        s_axis_tuser_i <= a.hit;
        nv = 1'b1;
        src_gap = gap_len();
      end
    end
    s_axis_tvalid_i <= nv;
  end

  // monitor
  int sink_gap = 0;
  always @(posedge clk_i) begin
    outcome_t g, e;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      // unpack the result word from the lowest bit up
      g.way        = m_axis_tdata_o[3:0];
      g.new_rrpv   = m_axis_tdata_o[5:4];
      g.streaming  = m_axis_tdata_o[6];
      g.lip_chosen = m_axis_tdata_o[7];
      n_got++;
      if (expected_results.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (g.way != e.way) report_mismatch("way", g.way, e.way);
        if (g.new_rrpv != e.new_rrpv) report_mismatch("new_rrpv", g.new_rrpv, e.new_rrpv);
        if (g.streaming != e.streaming) report_mismatch("streaming", g.streaming, e.streaming);
        if (g.lip_chosen != e.lip_chosen)
          report_mismatch("lip_chosen", g.lip_chosen, e.lip_chosen);
        n_hits += (g.new_rrpv == 0 && !g.lip_chosen);
        n_strm += g.streaming;
        n_lip += g.lip_chosen;
      end
    end
    if (sink_hold) begin
      m_axis_tready_i <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      sink_gap = gap_len();
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_cfg = val[1:0];
      REG_DECAY:     decay_cfg = val[15:0];
      REG_SEED:      lfsr = (val[15:0] == 0) ? 16'd1 : val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_accesses.size() > 0 || s_axis_tvalid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic push(int unsigned s, bit h, int unsigned w, logic [63:0] p, logic [63:0] ad);
    access_t a;
    a = {s[10:0], h, w[3:0], p, ad};
    pending_accesses.push_back(a);
  endtask

  task automatic push_random(int n);
    int unsigned s, c;
    logic [63:0] ad, p;
    for (int i = 0; i < n; i++) begin
      s = ($urandom_range(0, 9) < 8) ? set_pool[$urandom_range(0, 7)] : $urandom_range(0, SETS-1);
      c = $urandom_range(0, 99);
      if (c < 60) ad = gen_addr[s] + gen_stride[s];
      else if (c < 70) ad = gen_addr[s];
      else ad = {$urandom, $urandom};
      if ($urandom_range(0, 19) == 0) gen_stride[s] = {$urandom, $urandom};
      else if ($urandom_range(0, 9) == 0) gen_stride[s] = 64 * $urandom_range(1, 8);
      gen_addr[s] = ad;
      p = ($urandom_range(0, 3) != 0) ? pc_pool[$urandom_range(0, 7)] : {$urandom, $urandom};
      push(s, $urandom_range(0, 1), $urandom_range(0, 15), p, ad);
    end
  endtask

  initial begin
    for (int i = 0; i < SETS*WAYS; i++) begin
      blk_rrpv[i] = RRPV_MAX;
      blk_sig[i] = '0;
    end
    for (int i = 0; i < SIGN; i++) sig_ctr[i] = '0;
    for (int i = 0; i < SETS; i++) begin
      prev_addr[i] = '0;
      prev_stride[i] = '0;
      strm_ctr[i] = '0;
      gen_addr[i] = {$urandom, $urandom};
      gen_stride[i] = 64;
    end
    for (int i = 0; i < 8; i++) pc_pool[i] = {$urandom, $urandom};
    psel_ctr = PSEL_MID;
    fills = '0;
    thr_cfg = THR_RST;
    decay_cfg = DECAY_RST;
    lfsr = SEED_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, leader boundaries, a stride run into streaming, hits
    push(0, 0, 0, '0, '0);
    push(2047, 0, 15, '1, '1);
    push(31, 1, 15, '1, 64'h40);
    push(32, 1, 0, '0, 64'h80);
    push(2015, 0, 7, 64'h1234, 64'h1000);
    push(2016, 1, 3, 64'h1234, 64'h1000);
    for (int k = 1; k <= 6; k++) push(100, 0, 0, 64'h55, 64'h4000 + 64 * k);
    push(100, 1, 2, 64'h55, 64'h4000 + 64 * 7);
    push(100, 0, 0, 64'h55, 64'h4000);
    for (int k = 0; k < 4; k++) push(5, 1, k * 5, 64'h9, 64'h200 * k + 64'h300);
    for (int k = 0; k < 3; k++) push(5, 0, 0, 64'h9, 64'h777 + k);
    drain();

    reg_write(REG_THRESHOLD, 0);
    reg_write(REG_DECAY, 1);
    reg_write(REG_SEED, 0);
    push_random(30);
    drain();

    reg_write(REG_THRESHOLD, 1);
    reg_write(REG_DECAY, 65535);
    reg_write(REG_SEED, 1);
    push_random(300);
    repeat (100) @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    sink_hold = 1'b0;
    drain();

    reg_write(REG_THRESHOLD, 2);
    reg_write(REG_DECAY, 8);
    reg_write(REG_SEED, 16'hFFFF);
    push_random(200);
    drain();

    reg_write(REG_THRESHOLD, 3);
    reg_write(REG_DECAY, 64);
    reg_write(REG_SEED, $urandom_range(1, 65535));
    for (int b = 0; b < 10; b++) begin
      no_idle = (b % 3 == 1);
      push_random(95);
      while (pending_accesses.size() > 20) @(posedge clk_i);
    end
    no_idle = 1'b0;
    drain();

    $display("Accesses: %0d sent, %0d results checked; misses filled under LIP %0d times.",
             n_sent, n_got, n_lip);
    $display("Results with zero RRPV and no LIP: %0d; streaming results: %0d.", n_hits, n_strm);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
sv/sdsrr_pkg.sv
sv/sdsrr_ram.sv
sv/ship_dip_streaming_rrip_replacement.sv
tb/tb_ship_dip_streaming_rrip_replacement.sv
